[src/ssmt_pkg.sv]
// Shared constants, types and operation codes of the sorted sparse matrix table.
`timescale 1ns / 1ps
`default_nettype none
package ssmt_pkg;

    localparam int CAPACITY   = 64;
    localparam int INDEX_BITS = 16;
    localparam int KEY_W      = 2 * INDEX_BITS;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int SCAN_W     = $clog2(CAPACITY);

    // broadcast operation applied to every cell at once
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] row_index;
        logic [15:0] col_index;
        logic [63:0] write_value;
    } t_in;

    typedef struct packed {
        logic [63:0] read_value;
        logic        hit;
        logic [6:0]  entry_count;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [63:0]      value;
    } t_entry;

    typedef struct packed {
        logic        hit;
        logic [63:0] value;
    } t_acc;

    typedef struct packed {
        logic             clr;
        logic             scan;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [63:0]      wval;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[src/ssmt_cell.sv]
// One table cell: holds an entry, shifts with its neighbors, and forwards the lookup result.
`timescale 1ns / 1ps
`default_nettype none
module ssmt_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [ssmt_pkg::IDX_W-1:0]  i_idx,
    input  ssmt_pkg::t_cell_ctrl       i_ctrl,
    input  ssmt_pkg::t_entry           i_prev,
    input  wire                        i_prev_lt,
    input  ssmt_pkg::t_entry           i_next,
    input  ssmt_pkg::t_acc             i_acc,
    output ssmt_pkg::t_entry           o_entry,
    output logic                       o_lt,
    output ssmt_pkg::t_acc             o_acc
);
    import ssmt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_hit;
    logic   n_hit;
    logic [63:0] r_aval;
    logic [63:0] n_aval;
    logic   in_use;
    logic   lt;
    logic   eq;

    // only the first count cells hold live entries
    assign in_use = CNT_W'(i_idx) < i_ctrl.count;
    assign lt     = in_use && (r_entry.key < i_ctrl.key);
    assign eq     = in_use && (r_entry.key == i_ctrl.key);

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (!lt) begin
                    if (i_prev_lt) begin
                        n_entry.key   = i_ctrl.key;
                        n_entry.value = i_ctrl.wval;
                    end else begin
                        n_entry = i_prev;
                    end
                end
            end
            OP_DELETE: begin
                if (!lt) begin
                    n_entry = i_next;
                end
            end
            OP_UPDATE: begin
                if (eq) begin
                    n_entry.value = i_ctrl.wval;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_comb begin
        n_hit  = r_hit;
        n_aval = r_aval;
        if (i_ctrl.clr) begin
            n_hit  = 1'b0;
            n_aval = '0;
        end else if (i_ctrl.scan) begin
            n_hit  = i_acc.hit | eq;
            n_aval = i_acc.value | (eq ? r_entry.value : 64'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_aval  <= n_aval;
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_entry     = r_entry;
    assign o_lt        = lt;
    assign o_acc.hit   = r_hit;
    assign o_acc.value = r_aval;

endmodule
`default_nettype wire

[src/sorted_sparse_matrix_table_unit.sv]
// Top level of the sorted sparse matrix table: controller and row of cells.
//
// Usage: one input beat carries mode, row, column and write value; one output beat
// answers it with the value held before the beat, a hit flag, the entry count after
// the beat and an overflow flag for an insert dropped on a full table.
// The input channel is stalled while an item is in flight; one item is taken at a time.
// After acceptance the lookup result ripples down the cell row, one cell per cycle,
// through all CAPACITY cells in the scan state; then the apply state applies the insert,
// delete or update to all cells at once and loads the output register.
// The output register holds its beat while the receiver stalls; the next item may be
// accepted and scanned meanwhile, and waits in the apply state until the output frees.
// Reset (synchronous, active low) empties the table at once: the count goes to zero
// and stored entries beyond the count are never looked at.
`timescale 1ns / 1ps
`default_nettype none
module sorted_sparse_matrix_table_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  ssmt_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output ssmt_pkg::t_out    o_out_data
);
    import ssmt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SCAN_W-1:0] r_scan_cnt;
    logic [SCAN_W-1:0] n_scan_cnt;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [63:0]       r_wval;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out              r_out;
    t_out              n_out;

    logic              in_fire;
    logic              out_fire;
    logic              go;
    logic              wzero;
    logic [1:0]        op;
    logic              ovf;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic [CNT_W+6:0]  count_ext;
    t_cell_ctrl        ctrl;
    t_acc              last_acc;

    t_entry            ent   [CAPACITY];
    logic              lt    [CAPACITY];
    t_acc              acc   [CAPACITY];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_fire   = r_out_valid && !i_out_stall;
    assign go         = (r_state == S_APPLY) && !(r_out_valid && i_out_stall);

    assign row_ext  = {16'd0, i_in_data.row_index};
    assign col_ext  = {16'd0, i_in_data.col_index};
    assign last_acc = acc[CAPACITY-1];
    // both zero signs delete
    assign wzero    = (r_wval[62:0] == 63'd0);

    always_comb begin
        op  = OP_NONE;
        ovf = 1'b0;
        if (r_mode == MODE_WRITE) begin
            if (wzero) begin
                op = last_acc.hit ? OP_DELETE : OP_NONE;
            end else if (last_acc.hit) begin
                op = OP_UPDATE;
            end else if (r_count >= CNT_W'(CAPACITY)) begin
                ovf = 1'b1;
            end else begin
                op = OP_INSERT;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (go) begin
            case (op)
                OP_INSERT: n_count = r_count + 1'b1;
                OP_DELETE: n_count = r_count - 1'b1;
                default:   n_count = r_count;
            endcase
        end
    end

    assign count_ext = {7'd0, n_count};

    always_comb begin
        n_state     = r_state;
        n_scan_cnt  = r_scan_cnt;
        n_out_valid = r_out_valid && !out_fire;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state    = S_SCAN;
                    n_scan_cnt = '0;
                end
            end
            S_SCAN: begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                if (r_scan_cnt == SCAN_W'(CAPACITY - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (go) begin
                    n_state             = S_IDLE;
                    n_out_valid         = 1'b1;
                    n_out.read_value    = last_acc.value;
                    n_out.hit           = last_acc.hit;
                    n_out.entry_count   = count_ext[6:0];
                    n_out.overflow      = ovf;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_in_data.mode;
            r_key  <= {row_ext[INDEX_BITS-1:0], col_ext[INDEX_BITS-1:0]};
            r_wval <= i_in_data.write_value;
        end
        r_out      <= n_out;
        r_scan_cnt <= n_scan_cnt;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign ctrl.clr   = (r_state == S_IDLE);
    assign ctrl.scan  = (r_state == S_SCAN);
    assign ctrl.op    = go ? op : OP_NONE;
    assign ctrl.key   = r_key;
    assign ctrl.wval  = r_wval;
    assign ctrl.count = r_count;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry prev_e;
        t_entry next_e;
        logic   prev_lt;
        t_acc   acc_in;

        if (g == 0) begin : g_first
            assign prev_e  = ent[g];
            assign prev_lt = 1'b1;
            assign acc_in  = '0;
        end else begin : g_mid
            assign prev_e  = ent[g-1];
            assign prev_lt = lt[g-1];
            assign acc_in  = acc[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_e = ent[g];
        end else begin : g_inner
            assign next_e = ent[g+1];
        end

        ssmt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IDX_W'(g)),
            .i_ctrl    (ctrl),
            .i_prev    (prev_e),
            .i_prev_lt (prev_lt),
            .i_next    (next_e),
            .i_acc     (acc_in),
            .o_entry   (ent[g]),
            .o_lt      (lt[g]),
            .o_acc     (acc[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_only_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> $stable(r_count))
        else $error("entry count changed outside apply cycle");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_SCAN) && (r_scan_cnt == '0))
        else $error("accepted beat did not start a scan");

    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (!o_out_data.hit && (o_out_data.read_value == 64'd0)))
        else $error("overflow reported together with a hit");

endmodule
`default_nettype wire

[tb/tb_sorted_sparse_matrix_table_unit.sv]
// Testbench for the sorted sparse matrix table: directed rows, then random phases vs a predictor.
`timescale 1ns / 1ps
module tb_sorted_sparse_matrix_table_unit;
    import ssmt_pkg::*;

    localparam int LIMIT_CYCLES  = 1500000;
    localparam int PHASE_ITEMS   = 160;
    localparam int PHASE_COUNT   = 12;
    localparam int QUIET_ITEMS   = 150;
    localparam int POOL_SIZE     = 80;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_DBL  = 64'h3FF0_0000_0000_0000;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    typedef struct packed {
        t_in  beat;
        bit   has_lit;
        t_out lit;
    } t_dir_row;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    sorted_sparse_matrix_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state: sorted keys, values and the entry count
    logic [KEY_W-1:0] held_keys [CAPACITY];
    logic [63:0]      held_vals [CAPACITY];
    int               held_count = 0;

    t_out     pending_answers [$];
    t_dir_row dir_rows [$];
    logic [KEY_W-1:0] coord_pool [POOL_SIZE];

    int error_count = 0;
    int cycle_count = 0;
    int beat_count  = 0;
    int idle_pct    = 0;
    int stall_left  = 0;

    function automatic t_out sparse_access(t_in b);
        logic [KEY_W-1:0] key;
        int   p;
        int   i;
        bit   found;
        t_out r;
        key = {b.row_index[INDEX_BITS-1:0], b.col_index[INDEX_BITS-1:0]};
        p = 0;
        while (p < held_count && held_keys[p] < key) p++;
        found = (p < held_count) && (held_keys[p] == key);
        r.read_value = found ? held_vals[p] : 64'h0;
        r.hit        = found;
        r.overflow   = 1'b0;
        if (b.mode == MODE_WRITE) begin
            if (b.write_value[62:0] == 63'h0) begin
                // +0 and -0 both delete
                if (found) begin
                    for (i = p; i + 1 < held_count; i++) begin
                        held_keys[i] = held_keys[i+1];
                        held_vals[i] = held_vals[i+1];
                    end
                    held_count--;
                end
            end else if (found) begin
                held_vals[p] = b.write_value;
            end else if (held_count >= CAPACITY) begin
                r.overflow = 1'b1;
            end else begin
                for (i = held_count; i > p; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_vals[i] = held_vals[i-1];
                end
                held_keys[p] = key;
                held_vals[p] = b.write_value;
                held_count++;
            end
        end
        r.entry_count = 7'(held_count);
        return r;
    endfunction

    function automatic logic [63:0] nonzero_value();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {32'h7FF8_0000, $urandom};    // NaN
            1: v = 64'hFFFF_FFFF_FFFF_FFFF;
            2: v = 64'h0000_0000_0000_0001;
            3: v = 64'h8000_0000_0000_0001;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch beat %0d %s: got %h want %h", beat_count, what, got, want);
        error_count++;
    endtask

    task automatic add_row(input logic m, input logic [15:0] r, input logic [15:0] c,
                           input logic [63:0] v, input bit has_lit,
                           input logic [63:0] lv, input logic lh, input logic [6:0] lc);
        t_dir_row d;
        d.beat    = '{mode: m, row_index: r, col_index: c, write_value: v};
        d.has_lit = has_lit;
        d.lit     = '{read_value: lv, hit: lh, entry_count: lc, overflow: 1'b0};
        dir_rows.push_back(d);
    endtask

    // holds the beat until taken; the predictor runs at the accepting edge
    task automatic send_beat(input t_in b, input bit has_lit, input t_out lit);
        t_out want;
        int   bursts;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = sparse_access(b);
        pending_answers.push_back(has_lit ? lit : want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            // now and then a long run of bursts so the next beat lands mid-scan
            bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 1;
            repeat (bursts) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: check each taken beat, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.read_value, 64'h0);
            end else begin
                t_out want;
                want = pending_answers.pop_front();
                if (o_out_data.read_value !== want.read_value)
                    report_mismatch("read_value", o_out_data.read_value, want.read_value);
                if (o_out_data.hit !== want.hit)
                    report_mismatch("hit", 64'(o_out_data.hit), 64'(want.hit));
                if (o_out_data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_out_data.entry_count),
                                    64'(want.entry_count));
                if (o_out_data.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(o_out_data.overflow),
                                    64'(want.overflow));
            end
            beat_count++;
        end
        if (idle_pct == 0) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 99) < idle_pct / 2) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(1, 4) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        t_in    b;
        t_out   none;
        t_phase ph;
        int     del_pct;
        int     total;
        int     n;
        none  = '0;
        total = PHASE_COUNT * PHASE_ITEMS;

        // read before any write, extremes, -0 delete, NaN and denormal storage,
        // delete of an absent entry, in-place update, read ignoring write_value
        add_row(MODE_READ,  16'h0000, 16'h0000, 64'h0, 1'b1, 64'h0, 1'b0, 7'd0);
        add_row(MODE_READ,  16'hFFFF, 16'hFFFF, 64'h0, 1'b1, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h0000, 16'h0000, 64'h1, 1'b1, 64'h0, 1'b0, 7'd1);
        add_row(MODE_WRITE, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                1'b1, 64'h0, 1'b0, 7'd2);
        add_row(MODE_READ,  16'hFFFF, 16'hFFFF, 64'h0,
                1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd2);
        add_row(MODE_WRITE, 16'h8000, 16'h0001, 64'h7FF8_0000_0000_0001,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h0001, 16'h8000, 64'hFFF0_0000_0000_0000,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h0000, 16'hFFFF, 64'h8000_0000_0000_0001,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_READ,  16'h0000, 16'hFFFF, 64'h0, 1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'hFFFF, 16'hFFFF, NEG_ZERO,
                1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd4);
        add_row(MODE_WRITE, 16'hFFFF, 16'hFFFF, 64'h0, 1'b1, 64'h0, 1'b0, 7'd4);
        add_row(MODE_WRITE, 16'h0000, 16'h0000, ONE_DBL, 1'b1, 64'h1, 1'b1, 7'd4);
        add_row(MODE_READ,  16'h0000, 16'h0000, 64'h0, 1'b1, ONE_DBL, 1'b1, 7'd4);
        add_row(MODE_READ,  16'h0000, 16'h0001, 64'h0, 1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h0000, 16'h0000, 64'h0, 1'b1, ONE_DBL, 1'b1, 7'd3);
        add_row(MODE_WRITE, 16'h1234, 16'h5678, 64'h0000_0000_0000_0001,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h1234, 16'h5677, 64'h4000_0000_0000_0000,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h1234, 16'h5679, 64'hC000_0000_0000_0000,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_READ,  16'h1234, 16'h5678, 64'hFFFF_FFFF_FFFF_FFFF,
                1'b0, 64'h0, 1'b0, 7'd0);
        add_row(MODE_WRITE, 16'h8000, 16'h0001, NEG_ZERO, 1'b0, 64'h0, 1'b0, 7'd0);

        // half the pool clusters on a few rows so neighbors sort by column
        for (int i = 0; i < POOL_SIZE; i++) begin
            coord_pool[i] = {(i % 2) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                             16'($urandom)};
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 25;
        foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].has_lit,
                                        dir_rows[i].lit);
        wait_drained();

        n = 0;
        for (int k = 0; k < PHASE_COUNT; k++) begin
            ph = t_phase'(k % 3);
            case (ph)
                PH_FILL:  del_pct = 10;
                PH_DRAIN: del_pct = 70;
                default:  del_pct = 35;
            endcase
            idle_pct = (k % 4 == 3) ? 0 : 20 + 10 * (k % 3);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (n >= total - QUIET_ITEMS) idle_pct = 0;
                b.mode = ($urandom_range(0, 99) < 25) ? MODE_READ : MODE_WRITE;
                if ($urandom_range(0, 9) == 0)
                    {b.row_index, b.col_index} = $urandom;
                else
                    {b.row_index, b.col_index} = coord_pool[$urandom_range(0, POOL_SIZE-1)];
                if (b.mode == MODE_WRITE && $urandom_range(0, 99) < del_pct)
                    b.write_value = $urandom_range(0, 1) ? 64'h0 : NEG_ZERO;
                else
                    b.write_value = nonzero_value();
                send_beat(b, 1'b0, none);
                n++;
            end
            if (n < total - QUIET_ITEMS) wait_drained();
        end

        wait_drained();
        repeat (CAPACITY + 4) @(posedge i_clk);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
